@@ rtl/csl_pkg.sv @@
// Shared constants and control/status types for the cache set block.
package csl_pkg;

    // Parameter defaults
    localparam int unsigned WAYS_DEF        = 4;
    localparam int unsigned BLOCK_BYTES_DEF = 16;
    localparam int unsigned SET_BITS_DEF    = 4;
    localparam int unsigned ADDR_BITS_DEF   = 16;

    // Step counter covers up to 256 bytes per line plus the drain step
    localparam int unsigned CNT_W = 9;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic             clr_step;
        logic             latch;
        logic             lookup;
        logic             scan;
        logic             wb_step;
        logic             fill_step;
        logic             install;
        logic             access;
        logic             finish;
        logic [CNT_W-1:0] idx;
    } csl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic hit;
        logic need_wb;
        logic out_busy;
    } csl_stat_t;

endpackage

@@ rtl/csl_ctrl.sv @@
// Sequencer: clearing pass, lookup, victim scan, write-back, fill and access.
module csl_ctrl #(
    parameter int unsigned WAYS        = csl_pkg::WAYS_DEF,
    parameter int unsigned BLOCK_BYTES = csl_pkg::BLOCK_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  csl_pkg::csl_stat_t stat,
    output csl_pkg::csl_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_LOOKUP = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_WBACK  = 8'b0001_0000,
        S_FILL   = 8'b0010_0000,
        S_ACCESS = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    localparam logic [csl_pkg::CNT_W-1:0] LAST_WAY = csl_pkg::CNT_W'(WAYS - 1);
    localparam logic [csl_pkg::CNT_W-1:0] LINE_END = csl_pkg::CNT_W'(BLOCK_BYTES);

    state_t                    state_reg, state_next;
    logic [csl_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                cnt_next   = '0;
                state_next = stat.hit ? S_ACCESS : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (cnt_reg == LAST_WAY)
                begin
                    cnt_next   = '0;
                    state_next = S_WBACK;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_WBACK:
            begin
                if (!stat.need_wb || cnt_reg == LINE_END)
                begin
                    cnt_next   = '0;
                    state_next = S_FILL;
                end
                else
                begin
                    cmd.wb_step = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            S_FILL:
            begin
                if (cnt_reg == LINE_END)
                begin
                    cmd.install = 1'b1;
                    state_next  = S_ACCESS;
                end
                else
                begin
                    cmd.fill_step = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            S_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

endmodule

@@ rtl/csl_dp.sv @@
// Datapath: way tags and flags, line store, backing memory and result register.
module csl_dp #(
    parameter int unsigned WAYS        = csl_pkg::WAYS_DEF,
    parameter int unsigned BLOCK_BYTES = csl_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned SET_BITS    = csl_pkg::SET_BITS_DEF,
    parameter int unsigned ADDR_BITS   = csl_pkg::ADDR_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  csl_pkg::csl_cmd_t cmd,
    output csl_pkg::csl_stat_t stat,
    input  logic              in_cmd,
    input  logic [15:0]       in_address,
    input  logic [7:0]        in_write_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        read_data,
    output logic              hit,
    output logic              wrote_back,
    output logic [1:0]        victim_way
);

    localparam int unsigned OFF_BITS  = $clog2(BLOCK_BYTES);
    localparam int unsigned SET_COUNT = 1 << SET_BITS;
    localparam int unsigned TAG_RAW   = ADDR_BITS - OFF_BITS - SET_BITS;
    localparam int unsigned TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned LINE_N    = WAYS * BLOCK_BYTES;
    localparam int unsigned LINE_AW   = (LINE_N > 1) ? $clog2(LINE_N) : 1;
    localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;
    localparam int unsigned BlockSpan = BLOCK_BYTES * SET_COUNT;

    // Request registers
    logic                 wr_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [7:0]           wdata_reg;

    // Way state
    logic [WAYS-1:0]  valid_reg;
    logic [WAYS-1:0]  dirty_reg;
    logic [TAG_W-1:0] tag_reg   [WAYS];
    logic [31:0]      stamp_reg [WAYS];
    logic [31:0]      clock_reg;

    // Per-access working registers
    logic [WAY_W-1:0] way_reg;
    logic             hit_reg;
    logic             wb_reg;
    logic             inv_found_reg;
    logic [31:0]      best_stamp_reg;

    // Copy pipeline
    logic                      pend_wb_reg, pend_fill_reg;
    logic [csl_pkg::CNT_W-1:0] pend_idx_reg;

    // Clearing pass
    logic [ADDR_BITS-1:0] clr_idx_reg;

    // Memories
    logic [7:0] line_mem [LINE_N];
    logic [7:0] back_mem [MEM_DEPTH];
    logic [7:0] line_q, mem_q;

    // Result register
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_hit_reg, out_wb_reg;
    logic [1:0] out_way_reg;

    // Address fields
    logic [ADDR_BITS-1:0] in_addr_ext;
    logic [TAG_W-1:0]     req_tag;
    logic [ADDR_BITS-1:0] req_set;
    logic [ADDR_BITS-1:0] req_off;
    logic [ADDR_BITS-1:0] fill_base, wb_base;
    logic [WAY_W-1:0]     scan_way;
    logic                 hit_now;
    logic [WAY_W-1:0]     hit_way;

    assign in_addr_ext = ADDR_BITS'(32'(in_address));
    assign req_tag     = TAG_W'(addr_reg / BlockSpan);
    assign req_set     = ADDR_BITS'((addr_reg / BLOCK_BYTES) % SET_COUNT);
    assign req_off     = ADDR_BITS'(addr_reg % BLOCK_BYTES);
    assign fill_base   = addr_reg - req_off;
    assign wb_base     = ADDR_BITS'((32'(tag_reg[way_reg]) * SET_COUNT + 32'(req_set))
                                    * BLOCK_BYTES);
    assign scan_way    = WAY_W'(cmd.idx);

    // Tag compare, lowest matching way wins
    always_comb
    begin
        hit_now = 1'b0;
        hit_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_reg[i] == req_tag)
            begin
                hit_now = 1'b1;
                hit_way = WAY_W'(i);
            end
        end
    end

    assign stat.clr_last = &clr_idx_reg;
    assign stat.hit      = hit_now;
    assign stat.need_wb  = valid_reg[way_reg] & dirty_reg[way_reg];
    assign stat.out_busy = out_valid_reg & ~out_ready;

    // Control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            clock_reg     <= '0;
            clr_idx_reg   <= '0;
            pend_wb_reg   <= 1'b0;
            pend_fill_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WAYS; i++)
                stamp_reg[i] <= '0;
        end
        else
        begin
            pend_wb_reg   <= cmd.wb_step;
            pend_fill_reg <= cmd.fill_step;
            if (cmd.clr_step)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            if (cmd.install)
            begin
                valid_reg[way_reg] <= 1'b1;
                dirty_reg[way_reg] <= 1'b0;
            end
            if (cmd.access && wr_reg == csl_pkg::CMD_WRITE)
                dirty_reg[way_reg] <= 1'b1;
            if (cmd.finish)
            begin
                stamp_reg[way_reg] <= clock_reg;
                clock_reg          <= clock_reg + 1'b1;
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Request, lookup, victim scan, tag install and result capture
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= cmd.idx;
        if (cmd.latch)
        begin
            wr_reg        <= in_cmd;
            addr_reg      <= in_addr_ext;
            wdata_reg     <= in_write_data;
            wb_reg        <= 1'b0;
            inv_found_reg <= 1'b0;
        end
        if (cmd.lookup)
        begin
            hit_reg <= hit_now;
            way_reg <= hit_way;
        end
        if (cmd.scan && !inv_found_reg)
        begin
            if (!valid_reg[scan_way])
            begin
                way_reg       <= scan_way;
                inv_found_reg <= 1'b1;
            end
            else if (scan_way == '0 || stamp_reg[scan_way] < best_stamp_reg)
            begin
                way_reg        <= scan_way;
                best_stamp_reg <= stamp_reg[scan_way];
            end
        end
        if (cmd.wb_step)
            wb_reg <= 1'b1;
        if (cmd.install)
            tag_reg[way_reg] <= req_tag;
        if (cmd.finish)
        begin
            out_data_reg <= (wr_reg == csl_pkg::CMD_WRITE) ? wdata_reg : line_q;
            out_hit_reg  <= hit_reg;
            out_wb_reg   <= wb_reg;
            out_way_reg  <= 2'(32'(way_reg));
        end
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pend_fill_reg)
            line_mem[LINE_AW'(32'(way_reg) * BLOCK_BYTES + 32'(pend_idx_reg))] <= mem_q;
        else if (cmd.access && wr_reg == csl_pkg::CMD_WRITE)
            line_mem[LINE_AW'(32'(way_reg) * BLOCK_BYTES + 32'(req_off))] <= wdata_reg;
        if (cmd.wb_step)
            line_q <= line_mem[LINE_AW'(32'(way_reg) * BLOCK_BYTES + 32'(cmd.idx))];
        else if (cmd.access)
            line_q <= line_mem[LINE_AW'(32'(way_reg) * BLOCK_BYTES + 32'(req_off))];
    end

    // Backing memory: clear, write-back and fill
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            back_mem[clr_idx_reg] <= 8'h00;
        else if (pend_wb_reg)
            back_mem[ADDR_BITS'(wb_base + ADDR_BITS'(pend_idx_reg))] <= line_q;
        if (cmd.fill_step)
            mem_q <= back_mem[ADDR_BITS'(fill_base + ADDR_BITS'(cmd.idx))];
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_data_reg;
    assign hit        = out_hit_reg;
    assign wrote_back = out_wb_reg;
    assign victim_way = out_way_reg;

endmodule

@@ rtl/cache_set_lru_writeback_top.sv @@
// Top level of one write-back, write-allocate cache set with LRU replacement.
// Sequence: a hit goes from the lookup straight to the access and its result; a miss
// first scans the ways for a victim, writes a dirty victim back and then fills the
// line, both as byte-wide line copies, before the access.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: after rst_n is released, a clearing pass writes 2^ADDR_BITS zero
// bytes to the backing memory, one per cycle, before the first item is taken.
module cache_set_lru_writeback_top #(
    parameter int unsigned WAYS        = csl_pkg::WAYS_DEF,
    parameter int unsigned BLOCK_BYTES = csl_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned SET_BITS    = csl_pkg::SET_BITS_DEF,
    parameter int unsigned ADDR_BITS   = csl_pkg::ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // address[15:0], write_data[23:16]
    input  logic [0:0]  s_axis_tuser,  // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // read_data[7:0], hit[8], wrote_back[9],
                                       // victim_way[11:10], zero fill[15:12]
);

    csl_pkg::csl_cmd_t  cmd;
    csl_pkg::csl_stat_t stat;
    logic [7:0]         read_data;
    logic               hit, wrote_back;
    logic [1:0]         victim_way;

    csl_ctrl #(
        .WAYS        (WAYS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csl_dp #(
        .WAYS        (WAYS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .SET_BITS    (SET_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_cmd        (s_axis_tuser[0]),
        .in_address    (s_axis_tdata[15:0]),
        .in_write_data (s_axis_tdata[23:16]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .read_data     (read_data),
        .hit           (hit),
        .wrote_back    (wrote_back),
        .victim_way    (victim_way)
    );

    assign m_axis_tdata = {4'b0000, victim_way, wrote_back, hit, read_data};

endmodule

@@ test/cache_set_lru_writeback_checker.sv @@
// Checker for the cache set block: predicts each result and compares it on the master side.
module cache_set_lru_writeback_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // address[15:0], write_data[23:16]
    input  logic [0:0]  s_axis_tuser,  // cmd[0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,  // read_data[7:0], hit[8], wrote_back[9], victim_way[11:10]
    output int          fail_count,
    output int          pending,
    output int          hits_seen,
    output int          writebacks_seen
);

    localparam int NWAYS = csl_pkg::WAYS_DEF;
    localparam int LINE  = csl_pkg::BLOCK_BYTES_DEF;
    localparam int SETB  = csl_pkg::SET_BITS_DEF;

    // Packed from the top bit down, matching the result layout on tdata
    typedef struct packed {
        logic [1:0] way;
        logic       wb;
        logic       hit;
        logic [7:0] data;
    } access_result_t;

    // Shadow cache state
    logic        sh_valid [NWAYS];
    logic        sh_dirty [NWAYS];
    logic [15:0] sh_tag   [NWAYS];
    logic [31:0] sh_stamp [NWAYS];
    logic [31:0] sh_clock;
    logic [7:0]  sh_line  [NWAYS][LINE];
    logic [7:0]  sh_mem   [65536];

    access_result_t result_q[$];

    function automatic access_result_t predict_access(logic is_wr, logic [15:0] addr,
                                                       logic [7:0] wdata);
        int unsigned offset, set_idx, tag, w, base;
        logic hit, wb;
        access_result_t r;
        offset  = addr % LINE;
        set_idx = (addr / LINE) % (1 << SETB);
        tag     = (addr / LINE) >> SETB;
        hit = 1'b0;
        wb  = 1'b0;
        w   = 0;
        for (int i = NWAYS - 1; i >= 0; i--)
            if (sh_valid[i] && sh_tag[i] == tag)
            begin
                w = i;
                hit = 1'b1;
            end
        if (!hit)
        begin
            // victim: lowest invalid way, else oldest stamp
            w = NWAYS;
            for (int i = NWAYS - 1; i >= 0; i--)
                if (!sh_valid[i])
                    w = i;
            if (w == NWAYS)
            begin
                w = 0;
                for (int i = 1; i < NWAYS; i++)
                    if (sh_stamp[i] < sh_stamp[w])
                        w = i;
            end
            if (sh_valid[w] && sh_dirty[w])
            begin
                base = (sh_tag[w] * (1 << SETB) + set_idx) * LINE;
                for (int i = 0; i < LINE; i++)
                    sh_mem[16'(base + i)] = sh_line[w][i];
                wb = 1'b1;
            end
            base = addr - offset;
            for (int i = 0; i < LINE; i++)
                sh_line[w][i] = sh_mem[16'(base + i)];
            sh_tag[w]   = 16'(tag);
            sh_valid[w] = 1'b1;
            sh_dirty[w] = 1'b0;
        end
        if (is_wr == csl_pkg::CMD_WRITE)
        begin
            sh_line[w][offset] = wdata;
            sh_dirty[w] = 1'b1;
        end
        r.data = sh_line[w][offset];
        r.hit  = hit;
        r.wb   = wb;
        r.way  = w[1:0];
        sh_stamp[w] = sh_clock;
        sh_clock    = sh_clock + 1;
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < NWAYS; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_tag[i]   = '0;
            sh_stamp[i] = '0;
        end
        for (int i = 0; i < 65536; i++)
            sh_mem[i] = 8'h00;
        sh_clock = '0;
        fail_count = 0;
        pending = 0;
        hits_seen = 0;
        writebacks_seen = 0;
    end

    // Predict on accepted input, compare on accepted output
    always @(posedge clk)
    begin
        access_result_t exp_r, got_r;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_r = m_axis_tdata[11:0];
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (got_r !== exp_r)
                    begin
                        $display({"%0t: mismatch, expected data=%h hit=%b wb=%b way=%0d,",
                                  " actual data=%h hit=%b wb=%b way=%0d"},
                                 $time, exp_r.data, exp_r.hit, exp_r.wb, exp_r.way,
                                 got_r.data, got_r.hit, got_r.wb, got_r.way);
                        fail_count <= fail_count + 1;
                    end
                    if (got_r.hit) hits_seen <= hits_seen + 1;
                    if (got_r.wb) writebacks_seen <= writebacks_seen + 1;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(predict_access(s_axis_tuser[0], s_axis_tdata[15:0],
                                                  s_axis_tdata[23:16]));
            pending <= result_q.size();
        end
    end

endmodule

@@ test/cache_set_lru_writeback_top_tb.sv @@
// Testbench top for the cache set block: reset, stimulus, idling and verdict.
module cache_set_lru_writeback_top_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // address[15:0], write_data[23:16]
    logic [0:0]  s_axis_tuser = '0;  // cmd[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // read_data[7:0], hit[8], wrote_back[9], victim_way[11:10]

    int fail_count, pending, hits_seen, writebacks_seen;
    int items_sent;
    bit calm;  // no idling in the last part of the run

    always #1 clk = ~clk;

    cache_set_lru_writeback_top dut (.*);

    cache_set_lru_writeback_checker chk (.*);

    // Receiver stalls in random bursts
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall = $urandom_range(1, 5);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Present one access and hold it until taken
    task automatic send_access(logic cmd, logic [15:0] addr, logic [7:0] wdata);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wdata, addr};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Addresses that collide in a few sets, so evictions and write-backs are common
    function automatic logic [15:0] busy_addr();
        logic [15:0] a;
        a = 16'($urandom);
        a[7:6] = 2'b00;
        a[15:11] = $urandom_range(0, 3) == 0 ? a[15:11] : {3'b000, a[12:11]};
        return a;
    endfunction

    initial
    begin
        logic [15:0] a;
        calm = 1'b0;
        items_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, both kinds, fill of all ways, LRU eviction, wrap
        send_access(csl_pkg::CMD_READ,  16'h0000, 8'h00);
        send_access(csl_pkg::CMD_WRITE, 16'h0000, 8'hFF);
        send_access(csl_pkg::CMD_READ,  16'h0000, 8'h00);
        send_access(csl_pkg::CMD_WRITE, 16'hFFFF, 8'hA5);
        send_access(csl_pkg::CMD_READ,  16'hFFFF, 8'h00);
        send_access(csl_pkg::CMD_WRITE, 16'h0100, 8'h5A);
        send_access(csl_pkg::CMD_WRITE, 16'h0200, 8'h01);
        send_access(csl_pkg::CMD_WRITE, 16'h0300, 8'h80);
        send_access(csl_pkg::CMD_READ,  16'h0400, 8'h00);  // evicts oldest dirty way
        send_access(csl_pkg::CMD_READ,  16'h0000, 8'h00);  // brings back written byte
        send_access(csl_pkg::CMD_WRITE, 16'hFF0F, 8'h7E);
        send_access(csl_pkg::CMD_READ,  16'h0F0F, 8'h00);
        send_access(csl_pkg::CMD_WRITE, 16'h7FF0, 8'hC3);
        send_access(csl_pkg::CMD_READ,  16'h8000, 8'h00);
        send_access(csl_pkg::CMD_READ,  16'hFFF0, 8'h00);

        // Sender holds off until everything has come back
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || chk.result_q.size() != 0)
            @(posedge clk);

        // Random accesses, mostly into a crowded address range
        for (int n = 0; n < 1800; n++)
        begin
            if (n == 1500)
                calm = 1'b1;
            a = $urandom_range(0, 4) == 0 ? 16'($urandom) : busy_addr();
            send_access(1'($urandom), a, 8'($urandom));
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        while (chk.result_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("tb: %0d accesses, %0d hits, %0d write-backs checked", items_sent,
                 hits_seen, writebacks_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Overall time limit, clearing pass included
    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule
